### sv/isbn_pkg.sv
// ----------------------------------------------------------------------------
// isbn_pkg
// Shared types, character codes and small modulo helpers for the ISBN-10
// checker and ISBN-13 check digit block.
// ----------------------------------------------------------------------------
`default_nettype none

package isbn_pkg;

  localparam logic [7:0] CHAR_ZERO   = 8'h30;
  localparam logic [7:0] CHAR_NINE   = 8'h39;
  localparam logic [7:0] CHAR_X      = 8'h58;
  localparam logic [7:0] CHAR_HYPHEN = 8'h2d;

  localparam logic [3:0] DIGIT_X_VALUE = 4'd10;
  localparam logic [3:0] WEIGHT_START  = 4'd10;
  localparam logic [3:0] SUM10_SEED    = 4'd8;
  localparam logic [3:0] COUNT_MAX     = 4'd15;
  localparam logic [1:0] HYPHEN_MAX    = 2'd3;

  // classified character as it travels from front to back
  typedef struct packed {
    logic       last;
    logic       hyph;
    logic       isdig;
    logic [3:0] digit;
  } char_class_t;

  // v in 0..110, floor(v / 11) by reciprocal 187 / 2048
  function automatic logic [3:0] mod11(input logic [6:0] v);
    logic [14:0] p;
    logic [3:0]  q;
    logic [6:0]  r;
    p = 15'(v) * 15'd187;
    q = p[14:11];
    r = v - 7'(q) * 7'd11;
    return r[3:0];
  endfunction

  // v in 0..39, floor(v / 10) by reciprocal 205 / 2048
  function automatic logic [3:0] mod10(input logic [5:0] v);
    logic [13:0] p;
    logic [2:0]  q;
    logic [5:0]  r;
    p = 14'(v) * 14'd205;
    q = p[13:11];
    r = v - 6'(q) * 6'd10;
    return r[3:0];
  endfunction

endpackage

`default_nettype wire

### sv/isbn_in_if.sv
// ----------------------------------------------------------------------------
// isbn_in_if
// Character request channel: one ASCII character and its last mark.
// ----------------------------------------------------------------------------
`default_nettype none

interface isbn_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       last;

  modport source (output valid, output char_code, output last, input ready);
  modport sink   (input valid, input char_code, input last, output ready);
endinterface

`default_nettype wire

### sv/isbn_out_if.sv
// ----------------------------------------------------------------------------
// isbn_out_if
// Result request channel: validity of the ISBN-10 and the ISBN-13 check digit.
// ----------------------------------------------------------------------------
`default_nettype none

interface isbn_out_if;
  logic       valid;
  logic       ready;
  logic       valid_res;
  logic [3:0] check13;

  modport source (output valid, output valid_res, output check13, input ready);
  modport sink   (input valid, input valid_res, input check13, output ready);
endinterface

`default_nettype wire

### sv/isbn_front.sv
// ----------------------------------------------------------------------------
// isbn_front
// Accepts characters and classifies them as hyphen, digit or other, with the
// digit value ('X' counts ten), before they enter the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module isbn_front (
  isbn_in_if.sink              char_in,
  output logic                 push_valid,
  input  logic                 push_ready,
  output isbn_pkg::char_class_t push_data
);

  logic       is_num;
  logic       is_x;
  logic [7:0] offset;

  assign is_num = (char_in.char_code >= isbn_pkg::CHAR_ZERO) &&
                  (char_in.char_code <= isbn_pkg::CHAR_NINE);
  assign is_x   = (char_in.char_code == isbn_pkg::CHAR_X);
  assign offset = char_in.char_code - isbn_pkg::CHAR_ZERO;

  always_comb begin
    push_data.last  = char_in.last;
    push_data.hyph  = (char_in.char_code == isbn_pkg::CHAR_HYPHEN);
    push_data.isdig = is_num || is_x;
    if (is_x) begin
      push_data.digit = isbn_pkg::DIGIT_X_VALUE;
    end else if (is_num) begin
      push_data.digit = offset[3:0];
    end else begin
      push_data.digit = 4'd0;
    end
  end

  assign push_valid    = char_in.valid;
  assign char_in.ready = push_ready;

endmodule

`default_nettype wire

### sv/isbn_queue.sv
// ----------------------------------------------------------------------------
// isbn_queue
// Short first-in first-out queue of classified characters between the front
// and the back, so that each side stalls on its own.
// ----------------------------------------------------------------------------
`default_nettype none

module isbn_queue #(
  parameter int DEPTH = 2
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push_valid,
  output logic                  push_ready,
  input  isbn_pkg::char_class_t push_data,
  output logic                  pop_valid,
  input  logic                  pop_ready,
  output isbn_pkg::char_class_t pop_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  isbn_pkg::char_class_t mem [DEPTH];
  logic [PW-1:0] rd_ptr;
  logic [PW-1:0] wr_ptr;
  logic [CW-1:0] count;
  logic          push;
  logic          pop;

  assign push_ready = (count != CW'(DEPTH));
  assign pop_valid  = (count != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

### sv/isbn_back.sv
// ----------------------------------------------------------------------------
// isbn_back
// Running checks and sums over the classified characters; on the last
// character it registers the result and returns all state to its start.
// ----------------------------------------------------------------------------
`default_nettype none

module isbn_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_valid,
  output logic                  q_ready,
  input  isbn_pkg::char_class_t q_data,
  isbn_out_if.source            res_out
);

  logic [3:0] char_count,   char_count_next;
  logic [1:0] hyphen_count, hyphen_count_next;
  logic       prev_hyphen,  prev_hyphen_next;
  logic [3:0] digit_weight, digit_weight_next;
  logic [3:0] sum11,        sum11_next;
  logic [3:0] sum10,        sum10_next;
  logic       w3,           w3_next;
  logic       err,          err_next;

  logic       res_valid;
  logic       res_ok;
  logic [3:0] res_check;
  logic       ok;
  logic [3:0] check;
  logic       pop;

  logic [6:0] prod;
  logic [5:0] term;

  assign q_ready = !res_valid || res_out.ready;
  assign pop     = q_valid && q_ready;

  assign prod = 7'(digit_weight) * 7'(q_data.digit);
  assign term = w3 ? 6'(q_data.digit) * 6'd3 : 6'(q_data.digit);

  always_comb begin
    char_count_next   = char_count;
    hyphen_count_next = hyphen_count;
    digit_weight_next = digit_weight;
    sum11_next        = sum11;
    sum10_next        = sum10;
    w3_next           = w3;
    err_next          = err;
    prev_hyphen_next  = q_data.hyph;

    if (char_count == isbn_pkg::COUNT_MAX) begin
      err_next = 1'b1;
    end else begin
      char_count_next = char_count + 1'b1;
    end

    if (q_data.hyph) begin
      if ((char_count == 4'd0) || prev_hyphen || q_data.last) begin
        err_next = 1'b1;
      end
      if (hyphen_count == isbn_pkg::HYPHEN_MAX) begin
        err_next = 1'b1;
      end else begin
        hyphen_count_next = hyphen_count + 1'b1;
      end
    end else if (q_data.isdig) begin
      if (digit_weight == 4'd0) begin
        err_next = 1'b1;
      end else begin
        sum11_next        = isbn_pkg::mod11(7'(sum11) + prod);
        digit_weight_next = digit_weight - 1'b1;
      end
      if (!q_data.last) begin
        sum10_next = isbn_pkg::mod10(6'(sum10) + term);
        w3_next    = !w3;
      end
    end else begin
      err_next = 1'b1;
    end

    if (q_data.last && (hyphen_count_next == isbn_pkg::HYPHEN_MAX) && !prev_hyphen) begin
      err_next = 1'b1;
    end

    ok    = !err_next && (sum11_next == 4'd0);
    check = (!ok || (sum10_next == 4'd0)) ? 4'd0 : 4'd10 - sum10_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      char_count   <= 4'd0;
      hyphen_count <= 2'd0;
      prev_hyphen  <= 1'b0;
      digit_weight <= isbn_pkg::WEIGHT_START;
      sum11        <= 4'd0;
      sum10        <= isbn_pkg::SUM10_SEED;
      w3           <= 1'b1;
      err          <= 1'b0;
      res_valid    <= 1'b0;
    end else begin
      if (pop && q_data.last) begin
        char_count   <= 4'd0;
        hyphen_count <= 2'd0;
        prev_hyphen  <= 1'b0;
        digit_weight <= isbn_pkg::WEIGHT_START;
        sum11        <= 4'd0;
        sum10        <= isbn_pkg::SUM10_SEED;
        w3           <= 1'b1;
        err          <= 1'b0;
      end else if (pop) begin
        char_count   <= char_count_next;
        hyphen_count <= hyphen_count_next;
        prev_hyphen  <= prev_hyphen_next;
        digit_weight <= digit_weight_next;
        sum11        <= sum11_next;
        sum10        <= sum10_next;
        w3           <= w3_next;
        err          <= err_next;
      end
      if (pop && q_data.last) begin
        res_valid <= 1'b1;
      end else if (res_out.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && q_data.last) begin
      res_ok    <= ok;
      res_check <= check;
    end
  end

  assign res_out.valid     = res_valid;
  assign res_out.valid_res = res_ok;
  assign res_out.check13   = res_check;

`ifndef SYNTH
  a_sums_reduced: assert property (@(posedge clk) disable iff (rst)
    (sum11 < 4'd11) && (sum10 < 4'd10))
    else $error("running sums out of range");

  a_state_restart: assert property (@(posedge clk) disable iff (rst)
    (pop && q_data.last) |=>
      (char_count == 4'd0) && (digit_weight == isbn_pkg::WEIGHT_START) &&
      (sum10 == isbn_pkg::SUM10_SEED) && !err)
    else $error("state not restarted after last character");

  a_invalid_zero_check: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ok) |-> (res_check == 4'd0))
    else $error("check digit nonzero on invalid result");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_out.ready) |=> res_valid && $stable(res_ok) && $stable(res_check))
    else $error("stalled result changed");
`endif

endmodule

`default_nettype wire

### sv/isbn10_check_to_isbn13.sv
// ----------------------------------------------------------------------------
// isbn10_check_to_isbn13
// ISBN-10 validator that also yields the ISBN-13 check digit for prefix 978.
// ----------------------------------------------------------------------------
// Characters of one hyphenated ISBN-10 arrive one per request, the final one
// marked by last; exactly one result follows each last character. The block
// takes one character every cycle while the queue is not full; a character
// passes the front classifier into a queue of QUEUE_DEPTH entries and is
// popped and folded into the running sums by the back end; popping the last
// character loads the result register. The sustained rate of one character
// per cycle is set by the back end, which updates its state as it pops each
// character and pops whenever its result is not stalled; a stalled result
// holds the back end while the queue keeps taking characters until full.
`default_nettype none

module isbn10_check_to_isbn13 #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst,
  isbn_in_if.sink      char_in,
  isbn_out_if.source   res_out
);

  logic                  push_valid;
  logic                  push_ready;
  isbn_pkg::char_class_t push_data;
  logic                  q_valid;
  logic                  q_ready;
  isbn_pkg::char_class_t q_data;

  isbn_front u_front (
    .char_in    (char_in),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  isbn_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_data)
  );

  isbn_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_data  (q_data),
    .res_out (res_out)
  );

endmodule

`default_nettype wire
